// ===== rtl/lccm_pkg.sv =====
// Shared constants, codes and types of the lattice chain center-of-mass block.
// Used by every module under rtl except lccm_ram; depends on nothing.
package lccm_pkg;

   localparam int NUM_CHAINS       = 1024;
   localparam int MAX_CHAIN_LENGTH = 1024;

   localparam int CHAIN_W   = 10;
   localparam int COORD_W   = 12;
   localparam int POS_W     = 24;
   localparam int SUM_W     = 40;
   localparam int BOX_W     = 13;
   localparam int LEN_W     = 11;
   localparam int STEP_W    = 4;
   localparam int CENTER_W  = 32;
   localparam int FRAC_BITS = 8;
   localparam int NUM_AXES  = 3;
   localparam int AXIS_W    = 2;
   localparam int DIFF_W    = 26;

   localparam int DIV_NUM_W = SUM_W + FRAC_BITS;
   localparam int DIV_DEN_W = BOX_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BOX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_T        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_U        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_V        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN_LENGTH = 2'd3;

   localparam logic [BOX_W-1:0] BOX_RESET = 13'd64;
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd16;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam int STEP_BACK_BIT = 3;

   localparam logic [CENTER_W-1:0] CENTER_MAX = 32'h7FFF_FFFF;
   localparam logic [CENTER_W-1:0] CENTER_MIN = 32'h8000_0000;

   typedef struct packed {
      logic               kind;
      logic [CHAIN_W-1:0] chain_index;
      logic [COORD_W-1:0] start_t;
      logic [COORD_W-1:0] start_u;
      logic [COORD_W-1:0] start_v;
      logic               first_frame;
      logic [STEP_W-1:0]  step_code;
   } queue_item_type;

   typedef struct packed {
      logic [BOX_W-1:0] box_t;
      logic [BOX_W-1:0] box_u;
      logic [BOX_W-1:0] box_v;
      logic [LEN_W-1:0] chain_length;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

// ===== rtl/lattice_chain_center_of_mass.sv =====
// Top level of the lattice chain center-of-mass block: register file, front
// queue and back end. Depends on lccm_pkg, lccm_front and lccm_back.
//
// Usage: each chain arrives on the req_ channel as one start item (kind 0)
// with its wrapped start coordinate, then one step item (kind 1) per monomer.
// After chain_length steps one item leaves on the rsp_ channel with the chain
// index and the center of mass in signed fixed point with 8 fraction bits.
// The csr_ port writes the box sizes and the chain length.
// Step items are taken back to back while the back end is idle. A start item
// reads the stored start and, for each axis whose start has to be unwrapped,
// waits on one shared bit-serial divider that does 48 iterations per division.
// At the end of a chain the three center divisions run on that divider
// before the result is presented. A two-entry queue takes items in
// while the back end is busy. Reset is synchronous and active high; it loads
// the register defaults, clears the running position, sums and count, and
// leaves the stored starts of the previous frame undefined until written.
// A stalled receiver holds the result in the output register; the block
// finishes at most one more chain and then stops taking items.
module lattice_chain_center_of_mass import lccm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CHAIN_W-1:0]    req_chain_index,
   input  logic [COORD_W-1:0]    req_start_t,
   input  logic [COORD_W-1:0]    req_start_u,
   input  logic [COORD_W-1:0]    req_start_v,
   input  logic                  req_first_frame,
   input  logic [STEP_W-1:0]     req_step_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAIN_W-1:0]    rsp_out_chain,
   output logic [CENTER_W-1:0]   rsp_center_t,
   output logic [CENTER_W-1:0]   rsp_center_u,
   output logic [CENTER_W-1:0]   rsp_center_v
);

   cfg_type        cfg_ff, cfg_in;
   queue_item_type req_item;
   queue_item_type deq_item;
   logic           deq_valid;
   logic           deq_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BOX_T:        cfg_in.box_t        = csr_data;
            CSR_BOX_U:        cfg_in.box_u        = csr_data;
            CSR_BOX_V:        cfg_in.box_v        = csr_data;
            CSR_CHAIN_LENGTH: cfg_in.chain_length = csr_data[LEN_W-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_t        <= BOX_RESET;
         cfg_ff.box_u        <= BOX_RESET;
         cfg_ff.box_v        <= BOX_RESET;
         cfg_ff.chain_length <= LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.kind        = req_kind;
   assign req_item.chain_index = req_chain_index;
   assign req_item.start_t     = req_start_t;
   assign req_item.start_u     = req_start_u;
   assign req_item.start_v     = req_start_v;
   assign req_item.first_frame = req_first_frame;
   assign req_item.step_code   = req_step_code;

   lccm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_item  (deq_item)
   );

   lccm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .deq_valid     (deq_valid),
      .deq_ready     (deq_ready),
      .deq_item      (deq_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_chain (rsp_out_chain),
      .rsp_center_t  (rsp_center_t),
      .rsp_center_u  (rsp_center_u),
      .rsp_center_v  (rsp_center_v)
   );

endmodule

// ===== rtl/lccm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module lccm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lccm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by unwrapping and the
// center-of-mass division. Depends on lccm_pkg.
module lccm_div import lccm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign shifted = {rem_ff, quot_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== rtl/lccm_front.sv =====
// Front end: accepts items and holds them in a two-entry queue for the back end.
// Depends on lccm_pkg.
module lccm_front import lccm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  queue_item_type req_item,
   output logic           deq_valid,
   input  logic           deq_ready,
   output queue_item_type deq_item
);

   queue_item_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push, pop;

   assign req_ready = (count_ff != 2'd2);
   assign deq_valid = (count_ff != 2'd0);
   assign deq_item  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== rtl/lccm_back.sv =====
// Back end: unwraps chain starts against stored starts, walks and sums monomers,
// divides the sums into the center of mass. Depends on lccm_pkg, lccm_ram, lccm_div.
module lccm_back import lccm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                deq_valid,
   output logic                deq_ready,
   input  queue_item_type      deq_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAIN_W-1:0]  rsp_out_chain,
   output logic [CENTER_W-1:0] rsp_center_t,
   output logic [CENTER_W-1:0] rsp_center_u,
   output logic [CENTER_W-1:0] rsp_center_v
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UNWRAP = 3'd1;
   localparam logic [2:0] ST_UDIV   = 3'd2;
   localparam logic [2:0] ST_STORE  = 3'd3;
   localparam logic [2:0] ST_CDIV   = 3'd4;
   localparam logic [2:0] ST_CWAIT  = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   localparam int RAM_W = NUM_AXES * POS_W;

   logic [2:0]          state_ff, state_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   logic [POS_W-1:0]    pos_ff [NUM_AXES];
   logic [POS_W-1:0]    pos_in [NUM_AXES];
   logic [SUM_W-1:0]    sum_ff [NUM_AXES];
   logic [SUM_W-1:0]    sum_in [NUM_AXES];
   logic [CENTER_W-1:0] center_ff [NUM_AXES];
   logic [CENTER_W-1:0] center_in [NUM_AXES];
   logic [LEN_W-1:0]    count_ff, count_in;
   logic [CHAIN_W-1:0]  chain_ff, chain_in;
   logic [COORD_W-1:0]  raw_ff [NUM_AXES];
   logic [COORD_W-1:0]  raw_in [NUM_AXES];
   logic                first_ff, first_in;
   logic                stored_ff, stored_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAIN_W-1:0]  rsp_chain_ff, rsp_chain_in;
   logic [CENTER_W-1:0] rsp_center_ff [NUM_AXES];
   logic [CENTER_W-1:0] rsp_center_in [NUM_AXES];

   logic [LEN_W-1:0]    len_eff;
   logic [BOX_W-1:0]    box_arr [NUM_AXES];
   logic [POS_W-1:0]    prior_arr [NUM_AXES];
   logic [RAM_W-1:0]    ram_rdata;
   logic [RAM_W-1:0]    ram_wdata;
   logic                ram_we, ram_re;
   logic                stored_idx;
   logic                rsp_load;

   logic signed [DIFF_W-1:0] diff, half, box_ext, raw_ext, num_hi, num_lo, unw_num;
   logic signed [DIFF_W-1:0] q_times_box, unw_pos;
   logic                     above, below;
   logic [POS_W-1:0]         step_pos [NUM_AXES];
   logic [SUM_W-1:0]         sum_mag;
   logic [CENTER_W-1:0]      sat_center;
   logic                     sum_neg;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign len_eff = (cfg.chain_length > LEN_W'(MAX_CHAIN_LENGTH)) ?
                    LEN_W'(MAX_CHAIN_LENGTH) : cfg.chain_length;
   assign box_arr[0] = cfg.box_t;
   assign box_arr[1] = cfg.box_u;
   assign box_arr[2] = cfg.box_v;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         prior_arr[a] = ram_rdata[a*POS_W +: POS_W];
         ram_wdata[a*POS_W +: POS_W] = pos_ff[a];
      end
   end

   assign stored_idx = 32'(deq_item.chain_index) < NUM_CHAINS;

   // Unwrap of the current axis against the stored start.
   always_comb begin
      raw_ext = $signed({{(DIFF_W-COORD_W){1'b0}}, raw_ff[axis_ff]});
      diff    = raw_ext - $signed({{(DIFF_W-POS_W){prior_arr[axis_ff][POS_W-1]}},
                                   prior_arr[axis_ff]});
      box_ext = $signed({{(DIFF_W-BOX_W){1'b0}}, box_arr[axis_ff]});
      half    = $signed({{(DIFF_W-BOX_W+1){1'b0}}, box_arr[axis_ff][BOX_W-1:1]});
      above   = diff > half;
      below   = diff < -half;
      num_hi  = diff - half + box_ext - DIFF_W'(1);
      num_lo  = -half - diff + box_ext - DIFF_W'(1);
      unw_num = above ? num_hi : num_lo;
      q_times_box = unw_num - $signed({{(DIFF_W-DIV_DEN_W){1'b0}}, div_rsp.rem});
      unw_pos = above ? (raw_ext - q_times_box) : (raw_ext + q_times_box);
   end

   // Saturated center of the current axis from the divider result.
   always_comb begin
      sum_neg = sum_ff[axis_ff][SUM_W-1];
      sum_mag = sum_neg ? (~sum_ff[axis_ff] + SUM_W'(1)) : sum_ff[axis_ff];
      if (sum_neg) begin
         if (div_rsp.quot > {{(DIV_NUM_W-CENTER_W){1'b0}}, CENTER_MIN}) begin
            sat_center = CENTER_MIN;
         end else begin
            sat_center = ~div_rsp.quot[CENTER_W-1:0] + CENTER_W'(1);
         end
      end else if (div_rsp.quot > {{(DIV_NUM_W-CENTER_W){1'b0}}, CENTER_MAX}) begin
         sat_center = CENTER_MAX;
      end else begin
         sat_center = div_rsp.quot[CENTER_W-1:0];
      end
   end

   always_comb begin
      step_pos[0] = pos_ff[0] + POS_W'(deq_item.step_code[0])
                    - POS_W'(deq_item.step_code[STEP_BACK_BIT]);
      step_pos[1] = pos_ff[1] + POS_W'(deq_item.step_code[1])
                    - POS_W'(deq_item.step_code[STEP_BACK_BIT]);
      step_pos[2] = pos_ff[2] + POS_W'(deq_item.step_code[2])
                    - POS_W'(deq_item.step_code[STEP_BACK_BIT]);
   end

   assign deq_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      center_in    = center_ff;
      count_in     = count_ff;
      chain_in     = chain_ff;
      raw_in       = raw_ff;
      first_in     = first_ff;
      stored_in    = stored_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chain_in = rsp_chain_ff;
      rsp_center_in = rsp_center_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = {{(DIV_NUM_W-DIFF_W){1'b0}}, unw_num};
      div_req.den   = box_arr[axis_ff];
      unique case (state_ff)
         ST_IDLE: begin
            if (deq_valid) begin
               if (deq_item.kind == KIND_START) begin
                  ram_re    = 1'b1;
                  raw_in[0] = deq_item.start_t;
                  raw_in[1] = deq_item.start_u;
                  raw_in[2] = deq_item.start_v;
                  first_in  = deq_item.first_frame || !stored_idx;
                  stored_in = stored_idx;
                  chain_in  = deq_item.chain_index;
                  count_in  = '0;
                  for (int a = 0; a < NUM_AXES; a++) begin
                     sum_in[a] = '0;
                  end
                  axis_in  = '0;
                  state_in = ST_UNWRAP;
               end else if (count_ff < len_eff) begin
                  for (int a = 0; a < NUM_AXES; a++) begin
                     sum_in[a] = sum_ff[a] + {{(SUM_W-POS_W){pos_ff[a][POS_W-1]}}, pos_ff[a]};
                     pos_in[a] = step_pos[a];
                  end
                  count_in = count_ff + 1'b1;
                  if (count_in == len_eff) begin
                     axis_in  = '0;
                     state_in = ST_CDIV;
                  end
               end
            end
         end
         ST_UNWRAP: begin
            if (first_ff || box_arr[axis_ff] == '0 || (!above && !below)) begin
               pos_in[axis_ff] = {{(POS_W-COORD_W){1'b0}}, raw_ff[axis_ff]};
               if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
                  state_in = ST_STORE;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_UDIV;
            end
         end
         ST_UDIV: begin
            if (div_rsp.done) begin
               pos_in[axis_ff] = unw_pos[POS_W-1:0];
               if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
                  state_in = ST_STORE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_UNWRAP;
               end
            end
         end
         ST_STORE: begin
            ram_we   = stored_ff;
            state_in = ST_IDLE;
         end
         ST_CDIV: begin
            div_req.start = 1'b1;
            div_req.num   = {sum_mag, {FRAC_BITS{1'b0}}};
            div_req.den   = {{(DIV_DEN_W-LEN_W){1'b0}}, len_eff};
            state_in      = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (div_rsp.done) begin
               center_in[axis_ff] = sat_center;
               if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_CDIV;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_chain_in  = chain_ff;
               rsp_center_in = center_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         count_ff     <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            pos_ff[a] <= '0;
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
      end
      center_ff     <= center_in;
      raw_ff        <= raw_in;
      first_ff      <= first_in;
      stored_ff     <= stored_in;
      rsp_chain_ff  <= rsp_chain_in;
      rsp_center_ff <= rsp_center_in;
   end

   lccm_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_CHAINS)
   ) u_prior_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (chain_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (deq_item.chain_index),
      .rd_data (ram_rdata)
   );

   lccm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_chain = rsp_chain_ff;
   assign rsp_center_t  = rsp_center_ff[0];
   assign rsp_center_u  = rsp_center_ff[1];
   assign rsp_center_v  = rsp_center_ff[2];

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_div_wait_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UDIV || state_ff == ST_CWAIT) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on an idle divider");

   a_emit_full_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (count_ff == len_eff))
      else $error("result emitted before the chain was complete");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule
